// File: rtl/am2i_pkg.sv
// Package for the 2D affine matrix inverse: shared widths, the per-cell
// pipeline record and the register map. No dependencies.
package am2i_pkg;

    localparam int CW   = 32;          // coefficient width
    localparam int FB   = 16;          // fraction bits
    localparam int PW   = 2 * CW;      // product width (magnitude)
    localparam int DW   = PW + 1;      // magnitude of determinant
    localparam int NW   = PW + 2;      // translation numerator magnitude
    localparam int QW   = CW + 2;      // quotient bits kept (saturation guard)
    localparam int RATIO_BITS = 16;

    localparam logic [0:0] REG_RATIO = 1'b0;

    // One lane of division: a numerator magnitude, its sign and a quotient.
    typedef struct packed {
        logic          neg;
        logic [NW+2*FB-1:0] num;    // numerator already shifted left
        logic [QW-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic          vld;
        logic          sing;
        logic          dneg;
        logic [DW-1:0] den;
        logic [DW+1:0] rem0;
        logic [DW+1:0] rem1;
        logic [DW+1:0] rem2;
        logic [DW+1:0] rem3;
        logic [DW+1:0] rem4;
        logic [DW+1:0] rem5;
        lane_t         l0;
        lane_t         l1;
        lane_t         l2;
        lane_t         l3;
        lane_t         l4;
        lane_t         l5;
    } cell_t;

endpackage

// File: rtl/affine_2d_matrix_invert.sv
// Top level of the 2D affine matrix inverse: front-end products, a chain of
// division cells, and rounding/saturation at the output. Depends on am2i_pkg
// and am2i_div_cell.
//
//   channel  | dir | fields
//   s_axis   | in  | tdata: in_xx,in_xy,in_yx,in_yy,in_tx,in_ty (192 bits)
//   m_axis   | out | tdata: inv_xx..inv_ty (192 bits); tuser: singular
//   apb      | in  | reg 0 at 0x0: singular_ratio_limit (16 bits)
//
// One item enters per cycle unless the pipe is stalled. Four front-end stages
// come first, then one cell per numerator bit (the divider chain, LW = NW +
// 2*FB = 98 cells), then one output register that also rounds and saturates.
// The whole pipe advances together: it stalls only when the output register
// is full and m_axis_tready is low.
// rst_n clears all valid bits; payload registers are not reset.
module affine_2d_matrix_invert (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // in_xx[31:0], in_xy, in_yx, in_yy, in_tx, in_ty[191:160]
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // inv_xx[31:0], inv_xy, inv_yx, inv_yy, inv_tx, inv_ty[191:160]
    output logic [191:0] m_axis_tdata,
    // singular[0]
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CW = am2i_pkg::CW;
    localparam int PW = am2i_pkg::PW;
    localparam int DW = am2i_pkg::DW;
    localparam int NW = am2i_pkg::NW;
    localparam int FB = am2i_pkg::FB;
    localparam int QW = am2i_pkg::QW;
    localparam int LW = NW + 2 * FB;
    localparam int NCELL = LW;

    logic [15:0] ratio_reg;
    logic        adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == am2i_pkg::REG_RATIO) ? {16'd0, ratio_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= 16'd1;
        end
        else if (psel && penable && pwrite && paddr[2] == am2i_pkg::REG_RATIO)
        begin
            ratio_reg <= pwdata[15:0];
        end
    end

    // The pipe moves whenever the output register is empty or being drained.
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: six signed products.
    logic signed [CW-1:0] a, b, c, d, tx, ty;
    assign a  = s_axis_tdata[31:0];
    assign b  = s_axis_tdata[63:32];
    assign c  = s_axis_tdata[95:64];
    assign d  = s_axis_tdata[127:96];
    assign tx = s_axis_tdata[159:128];
    assign ty = s_axis_tdata[191:160];

    logic                 v1_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, cty_reg, dtx_reg, btx_reg, aty_reg;
    logic signed [CW-1:0] a1_reg, b1_reg, c1_reg, d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= a * d;
            p2_reg  <= b * c;
            cty_reg <= c * ty;
            dtx_reg <= d * tx;
            btx_reg <= b * tx;
            aty_reg <= a * ty;
            a1_reg <= a;
            b1_reg <= b;
            c1_reg <= c;
            d1_reg <= d;
        end
    end

    // Stage 2: determinant, magnitude sum, translation numerators.
    logic                   v2_reg;
    logic signed [PW:0]     det2_reg, nx2_reg, ny2_reg;
    logic [PW:0]            sum2_reg;
    logic signed [CW-1:0]   a2_reg, b2_reg, c2_reg, d2_reg;
    logic [PW-1:0]          m1, m2;

    assign m1 = p1_reg[PW-1] ? PW'(-p1_reg) : PW'(p1_reg);
    assign m2 = p2_reg[PW-1] ? PW'(-p2_reg) : PW'(p2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det2_reg <= {p1_reg[PW-1], p1_reg} - {p2_reg[PW-1], p2_reg};
            sum2_reg <= {1'b0, m1} + {1'b0, m2};
            nx2_reg  <= {cty_reg[PW-1], cty_reg} - {dtx_reg[PW-1], dtx_reg};
            ny2_reg  <= {btx_reg[PW-1], btx_reg} - {aty_reg[PW-1], aty_reg};
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
            c2_reg <= c1_reg;
            d2_reg <= d1_reg;
        end
    end

    // Stage 3: |det| and the threshold product.
    logic               v3_reg;
    logic [DW-1:0]      dm3_reg;
    logic               dn3_reg;
    logic [DW+15:0]     rhs3_reg;
    logic signed [PW:0] nx3_reg, ny3_reg;
    logic signed [CW-1:0] a3_reg, b3_reg, c3_reg, d3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dm3_reg  <= det2_reg[PW] ? DW'(-det2_reg) : DW'(det2_reg);
            dn3_reg  <= det2_reg[PW];
            rhs3_reg <= (DW + 16)'(sum2_reg) * (DW + 16)'(ratio_reg);
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            a3_reg <= a2_reg;
            b3_reg <= b2_reg;
            c3_reg <= c2_reg;
            d3_reg <= d2_reg;
        end
    end

    // Stage 4: singular decision and loading of the division lanes.
    function automatic am2i_pkg::lane_t mk_lane(input logic signed [PW:0] v, input int sh);
        am2i_pkg::lane_t l;
        logic [NW-1:0] m;
        begin
            m = v[PW] ? NW'(-v) : NW'(v);
            l.neg = v[PW];
            l.num = LW'(m) << sh;
            l.quo = '0;
            mk_lane = l;
        end
    endfunction

    am2i_pkg::cell_t chain [0:NCELL];
    am2i_pkg::cell_t c4;

    always_comb
    begin
        c4.vld  = v3_reg;
        c4.sing = (dm3_reg == '0) ||
                  ({dm3_reg, 16'd0} < rhs3_reg);
        c4.dneg = dn3_reg;
        c4.den  = dm3_reg;
        c4.rem0 = '0;
        c4.rem1 = '0;
        c4.rem2 = '0;
        c4.rem3 = '0;
        c4.rem4 = '0;
        c4.rem5 = '0;
        c4.l0 = mk_lane((PW + 1)'(d3_reg), 2 * FB);
        c4.l1 = mk_lane(-(PW + 1)'(b3_reg), 2 * FB);
        c4.l2 = mk_lane(-(PW + 1)'(c3_reg), 2 * FB);
        c4.l3 = mk_lane((PW + 1)'(a3_reg), 2 * FB);
        c4.l4 = mk_lane(nx3_reg, FB);
        c4.l5 = mk_lane(ny3_reg, FB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chain[0].vld <= 1'b0;
        else if (adv)
            chain[0] <= c4;
    end

    // Division chain, most significant numerator bit first. The quotient
    // register keeps only its low QW-1 bits plus a sticky overflow held in the
    // top bit, so large quotients still saturate.
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            am2i_div_cell #(.BIT(LW - 1 - gi)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (adv),
                .din  (chain[gi]),
                .dout (chain[gi + 1])
            );
        end
    endgenerate

    // Output: round (one more remainder step), saturate, sign.
    function automatic logic [CW-1:0] fin(input am2i_pkg::lane_t l,
                                          input logic [DW+1:0] r,
                                          input logic [DW-1:0] dd,
                                          input logic dn);
        logic [QW:0]   q;
        logic          ng;
        logic          up;
        logic [CW-1:0] res;
        begin
            up = ({r[DW:0], 1'b0}) >= {1'b0, dd};
            q = {1'b0, l.quo} + {{QW{1'b0}}, up};
            ng = (l.neg != dn) && (q != '0);
            if (ng)
                res = (q >= (QW + 1)'(1) << (CW - 1)) ? {1'b1, {(CW - 1){1'b0}}}
                                                     : CW'(-q);
            else
                res = (q >= (QW + 1)'(1) << (CW - 1)) ? {1'b0, {(CW - 1){1'b1}}}
                                                     : CW'(q);
            fin = res;
        end
    endfunction

    am2i_pkg::cell_t e;
    assign e = chain[NCELL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (adv)
            m_axis_tvalid <= e.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_axis_tuser <= e.sing;
            if (e.sing)
                m_axis_tdata <= '0;
            else
                m_axis_tdata <= {fin(e.l5, e.rem5, e.den, e.dneg),
                                 fin(e.l4, e.rem4, e.den, e.dneg),
                                 fin(e.l3, e.rem3, e.den, e.dneg),
                                 fin(e.l2, e.rem2, e.den, e.dneg),
                                 fin(e.l1, e.rem1, e.den, e.dneg),
                                 fin(e.l0, e.rem0, e.den, e.dneg)};
        end
    end

endmodule

// File: rtl/am2i_div_cell.sv
// One restoring-division step cell of the divider chain: it brings one numerator
// bit per lane into the partial remainder and emits one quotient bit.
// Depends on am2i_pkg.
module am2i_div_cell #(
    parameter int BIT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  am2i_pkg::cell_t   din,
    output am2i_pkg::cell_t   dout
);

    am2i_pkg::cell_t nxt;

    // The quotient keeps its low QW-1 bits exactly; the top bit is sticky and
    // collects every bit that is shifted past it, so an oversized quotient
    // is still recognized at the output.
    function automatic void step(
        input  logic [am2i_pkg::DW+1:0] r,
        input  am2i_pkg::lane_t l,
        input  logic [am2i_pkg::DW-1:0] d,
        output logic [am2i_pkg::DW+1:0] ro,
        output am2i_pkg::lane_t lo
    );
        logic [am2i_pkg::DW+1:0] t;
        logic                    sticky;
        begin
            t      = {r[am2i_pkg::DW:0], l.num[BIT]};
            lo     = l;
            sticky = l.quo[am2i_pkg::QW-1] | l.quo[am2i_pkg::QW-2];
            if (t >= {2'b00, d})
            begin
                ro = t - {2'b00, d};
                lo.quo = {sticky, l.quo[am2i_pkg::QW-3:0], 1'b1};
            end
            else
            begin
                ro = t;
                lo.quo = {sticky, l.quo[am2i_pkg::QW-3:0], 1'b0};
            end
        end
    endfunction

    always_comb
    begin
        nxt = din;
        step(din.rem0, din.l0, din.den, nxt.rem0, nxt.l0);
        step(din.rem1, din.l1, din.den, nxt.rem1, nxt.l1);
        step(din.rem2, din.l2, din.den, nxt.rem2, nxt.l2);
        step(din.rem3, din.l3, din.den, nxt.rem3, nxt.l3);
        step(din.rem4, din.l4, din.den, nxt.rem4, nxt.l4);
        step(din.rem5, din.l5, din.den, nxt.rem5, nxt.l5);
    end

    // Only the valid bit is cleared by reset; the payload just holds.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout.vld <= 1'b0;
        end
        else if (en)
        begin
            dout <= nxt;
        end
    end

endmodule

// File: rtl/am2i_checker.sv
// Port-level checker for the affine inverse, bound to the top level.
// Depends on the top level's ports only.
module am2i_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [191:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("singular item carries nonzero data");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while the pipe is stalled");

endmodule

bind affine_2d_matrix_invert am2i_checker u_am2i_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
